FILE: hw/rtl/sitoa_pkg.sv
// Shared types, constants and conversion step for the signed integer to decimal text block.
`timescale 1ns / 1ps

package sitoa_pkg;

  localparam int ValueW        = 32;
  localparam int DigitW        = 4;
  localparam int NumDigits     = 10;
  localparam int BcdW          = NumDigits * DigitW;
  localparam int StepsPerStage = 4;
  localparam int DabbleStages  = ValueW / StepsPerStage;
  localparam int PosW          = 4;
  localparam int CharW         = 8;

  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharZero  = 8'd48;

  typedef logic [ValueW-1:0]        mag_t;
  typedef logic [BcdW-1:0]          bcd_t;
  typedef logic [PosW-1:0]          pos_t;
  typedef logic [CharW-1:0]         char_t;
  typedef logic [DigitW-1:0]        digit_t;
  typedef logic [BcdW+ValueW-1:0]   dabble_t;

  // Shift-and-add-3 conversion: StepsPerStage binary bits move into the BCD field.
  function automatic dabble_t dabble_stage(input bcd_t bcd_in, input mag_t bin_in);
    dabble_t acc;
    acc = {bcd_in, bin_in};
    for (int t = 0; t < StepsPerStage; t++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (acc[ValueW + d*DigitW +: DigitW] >= digit_t'(5)) begin
          acc[ValueW + d*DigitW +: DigitW] = acc[ValueW + d*DigitW +: DigitW] + digit_t'(3);
        end
      end
      acc = {acc[BcdW+ValueW-2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII character stream, top level.
`timescale 1ns / 1ps

// Each accepted 32-bit two's complement integer comes out as its decimal text, one ASCII
// character per output transaction, most significant digit first, with a leading '-' for
// negative values and tlast on the final character. Zero gives a single '0'; the most
// negative value gives "-2147483648". A run is 1 to 11 characters. Conversion runs in a
// ten-stage pipeline (magnitude, eight binary-to-BCD stages of four bits each, leading
// digit search), so the first character is offered once the leading digit stage has
// handed its run to the output serialiser.
// The output character serialiser sets the rate: a number whose text is n characters
// holds the output for n transactions. Further inputs are accepted while it sends, and
// with m_tready held high the next run follows its predecessor's last character at once.
// Once a finished run waits in the leading digit stage, the whole pipeline holds in place
// until the serialiser loads it, so a stall on the output also holds the pipeline.
module signed_int_to_decimal_ascii (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic signed [31:0]  s_tdata,   // [31:0] value
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] character
  output logic                m_tlast    // last character of the run
);

  localparam int NS = sitoa_pkg::DabbleStages;

  // Pipeline stage registers: index 0 holds the magnitude, index NS the finished BCD.
  logic [NS:0]           dv;
  sitoa_pkg::bcd_t       dbcd [0:NS];
  sitoa_pkg::mag_t       dbin [0:NS];
  logic [NS:0]           dneg;
  sitoa_pkg::dabble_t    dab_next [0:NS-1];

  // Leading digit stage.
  logic                  tv;
  sitoa_pkg::bcd_t       tbcd;
  logic                  tneg;
  sitoa_pkg::pos_t       tpos;
  sitoa_pkg::pos_t       tpos_next;

  // Output serialiser.
  logic                  busy;
  logic                  sneg;
  sitoa_pkg::pos_t       spos;
  sitoa_pkg::bcd_t       sbcd;

  sitoa_pkg::mag_t       raw;
  sitoa_pkg::mag_t       mag;
  sitoa_pkg::digit_t     cur_digit;
  logic                  last_char;
  logic                  take;
  logic                  load;
  logic                  adv;

  // Magnitude in unsigned arithmetic, so the most negative value needs no special case.
  assign raw = sitoa_pkg::mag_t'(s_tdata);
  assign mag = raw[sitoa_pkg::ValueW-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      dab_next[s] = sitoa_pkg::dabble_stage(dbcd[s], dbin[s]);
    end
  end

  // Position of the most significant non-zero digit; zero keeps position 0.
  always_comb begin
    tpos_next = '0;
    for (int d = 0; d < sitoa_pkg::NumDigits; d++) begin
      if (dbcd[NS][d*sitoa_pkg::DigitW +: sitoa_pkg::DigitW] != '0) begin
        tpos_next = sitoa_pkg::pos_t'(d);
      end
    end
  end

  // Handshake: the serialiser takes a new run when empty or when its last character leaves;
  // the pipeline advances whenever its final stage is empty or being taken.
  assign last_char = !sneg && (spos == '0);
  assign take      = busy && m_tready;
  assign load      = tv && (!busy || (m_tready && last_char));
  assign adv       = !tv || load;
  assign s_tready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      tv <= 1'b0;
    end else if (adv) begin
      dv <= {dv[NS-1:0], s_tvalid};
      tv <= dv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dbcd[0] <= '0;
      dbin[0] <= mag;
      dneg[0] <= s_tdata[sitoa_pkg::ValueW-1];
      for (int s = 0; s < NS; s++) begin
        dbcd[s+1] <= dab_next[s][sitoa_pkg::ValueW +: sitoa_pkg::BcdW];
        dbin[s+1] <= dab_next[s][sitoa_pkg::ValueW-1:0];
        dneg[s+1] <= dneg[s];
      end
      tbcd <= dbcd[NS];
      tneg <= dneg[NS];
      tpos <= tpos_next;
    end
  end

  // Serialiser control: emit '-' first when negative, then count digits down to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sneg <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      sneg <= tneg;
    end else if (take) begin
      if (sneg) begin
        sneg <= 1'b0;
      end else if (spos == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sbcd <= tbcd;
      spos <= tpos;
    end else if (take && !sneg && (spos != '0)) begin
      spos <= spos - 1'b1;
    end
  end

  assign cur_digit = sbcd[{spos, 2'b00} +: sitoa_pkg::DigitW];

  assign m_tvalid = busy;
  assign m_tlast  = last_char;
  assign m_tdata  = sneg ? sitoa_pkg::CharMinus
                         : sitoa_pkg::CharZero + {4'b0000, cur_digit};

endmodule

FILE: hw/rtl/sitoa_checker.sv
// Port-level checks for the signed integer to decimal text block, bound to the top level.
`timescale 1ns / 1ps

module sitoa_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Hold a stalled output transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  // Only '-' or a decimal digit ever appears.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == sitoa_pkg::CharMinus) ||
                 ((m_tdata >= sitoa_pkg::CharZero) && (m_tdata <= sitoa_pkg::CharZero + 8'd9)))
    else $error("output character outside '-' and digits");

  // A sign never ends a run.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == sitoa_pkg::CharMinus) |-> !m_tlast)
    else $error("sign flagged as last character");

  // Within a run the next character follows at once and is a digit.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tdata != sitoa_pkg::CharMinus))
    else $error("run broken or sign inside run");

  // After a '-' sign, a run of more than one digit does not start with '0'.
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata == sitoa_pkg::CharMinus) |=>
      !(m_tdata == sitoa_pkg::CharZero && !m_tlast))
    else $error("leading zero after sign");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (.*);
